// ===== src/lla_pkg.sv =====
// lla_pkg: shared types and constants for the lane line averager
// depends on nothing
`timescale 1ns / 1ps
package lla_pkg;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BOTTOM = 2'd3;
  localparam logic [15:0] TAN_LOW_RST = 16'd148;
  localparam logic [15:0] TAN_HIGH_RST = 16'd1452;
  localparam logic [11:0] ROW_TOP_RST = 12'd208;
  localparam logic [11:0] ROW_BOTTOM_RST = 12'd320;
  localparam int SUM_W = 48;
  localparam int NUM_W = 64;
  localparam int QUO_W = 64;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word and compute slope test
    logic div_start;  // start the shared divider
    logic div_sel;    // 0 slope, 1 column
    logic accum;      // add finished segment into lane sums
    logic col_side;   // lane under evaluation
    logic col_row;    // 0 top row, 1 bottom row
    logic col_save;   // store divider result as column
    logic out_load;   // load output register
    logic clear;      // clear lane sums
  } lla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic keep;       // segment passes tests
    logic div_done;
    logic lane_ok;    // lane under evaluation has n != 0 and sum_m != 0
  } lla_sts_t;
endpackage

// ===== src/lane_line_averager.sv =====
// lane_line_averager: top level, configuration registers and module wiring
// depends on lla_pkg, lla_ctrl, lla_datapath
//
// usage: segments enter on the in_ channel (valid/stall), one word per segment;
// a word with frame_last set closes the frame and causes two result words on
// the out_ channel, left lane first, then right lane with pair_last set.
// a kept segment is tested, then the shared 64-step bit-serial divider
// forms the slope; a rejected or empty segment needs no slope division.
// frame end adds two column divisions per found lane.
// in_stall is high whenever the sequencer is busy; one item is in flight.
// the result word sits in an output register; while out_stall is high it
// holds and the sequencer waits before loading the next word.
// reset clears lane sums and loads default thresholds and rows.
// cfg_ writes are taken at any time; cfg_ready is always high.
`timescale 1ns / 1ps
module lane_line_averager #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_has_segment,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  input  logic                  in_frame_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_lane_side,
  output logic                  out_lane_found,
  output logic signed [15:0]    out_col_top,
  output logic [11:0]           out_top_row,
  output logic signed [15:0]    out_col_bottom,
  output logic [11:0]           out_bottom_row,
  output logic                  out_pair_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]           cfg_data
);
  import lla_pkg::*;

  logic [15:0] tan_low_r, tan_high_r;
  logic [11:0] row_top_r, row_bottom_r;
  lla_cmd_t cmd;
  lla_sts_t sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_low_r <= TAN_LOW_RST; tan_high_r <= TAN_HIGH_RST;
      row_top_r <= ROW_TOP_RST; row_bottom_r <= ROW_BOTTOM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAN_LOW: tan_low_r <= cfg_data;
        REG_TAN_HIGH: tan_high_r <= cfg_data;
        REG_ROW_TOP: row_top_r <= cfg_data[11:0];
        REG_ROW_BOTTOM: row_bottom_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  lla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_has_segment(in_has_segment), .in_frame_last(in_frame_last),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  lla_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .x_start(in_x_start), .y_start(in_y_start), .x_end(in_x_end), .y_end(in_y_end),
    .tan_low(tan_low_r), .tan_high(tan_high_r),
    .row_top(row_top_r), .row_bottom(row_bottom_r),
    .o_side(out_lane_side), .o_found(out_lane_found),
    .o_col_top(out_col_top), .o_top_row(out_top_row),
    .o_col_bottom(out_col_bottom), .o_bottom_row(out_bottom_row)
  );

  assign out_pair_last = out_lane_side;
endmodule

// ===== src/lla_div.sv =====
// lla_div: signed restoring divider, one quotient bit a cycle, truncates toward zero
// depends on lla_pkg
`timescale 1ns / 1ps
module lla_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [lla_pkg::NUM_W-1:0] num,
  input  logic signed [lla_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic signed [lla_pkg::QUO_W-1:0] quo
);
  import lla_pkg::*;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [SUM_W:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0] d_r, d_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W:0]   trial;
  logic [SUM_W+1:0] diff;

  always_comb begin
    trial = {rem_r[SUM_W-1:0], q_r[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, d_r};
  end

  // iterate over quotient bits
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = num[NUM_W-1] ? NUM_W'(-num) : num;
      d_nxt = den[SUM_W-1] ? SUM_W'(-den) : den;
      neg_nxt = num[NUM_W-1] ^ den[SUM_W-1];
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[SUM_W+1]) begin
        rem_nxt = diff[SUM_W:0];
        q_nxt = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? QUO_W'(-q_r) : QUO_W'(q_r);
endmodule

// ===== src/lla_datapath.sv =====
// lla_datapath: segment tests, lane sums, column numerators and output register
// depends on lla_pkg and lla_div
`timescale 1ns / 1ps
module lla_datapath #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lla_pkg::lla_cmd_t     cmd,
  output lla_pkg::lla_sts_t     sts,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [15:0]           tan_low,
  input  logic [15:0]           tan_high,
  input  logic [11:0]           row_top,
  input  logic [11:0]           row_bottom,
  output logic                  o_side,
  output logic                  o_found,
  output logic signed [15:0]    o_col_top,
  output logic [11:0]           o_top_row,
  output logic signed [15:0]    o_col_bottom,
  output logic [11:0]           o_bottom_row
);
  import lla_pkg::*;
  localparam int CW = COORD_BITS + 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int PW = COORD_BITS + 17;

  logic signed [CW-1:0] dx_r, dy_r;
  logic [COORD_BITS-1:0] xs_r, ys_r;
  logic                 keep_r;
  logic signed [CW-1:0] dx, dy;
  logic [CW-1:0]        adx, ady;
  logic [CW+16:0]       tl_prod, th_prod, ady_sh;

  // capture segment and run the slope window test
  always_comb begin
    dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx = dx[CW-1] ? CW'(-dx) : CW'(dx);
    ady = dy[CW-1] ? CW'(-dy) : CW'(dy);
    tl_prod = (CW+17)'(tan_low) * (CW+17)'(adx);
    th_prod = (CW+17)'(tan_high) * (CW+17)'(adx);
    ady_sh = (CW+17)'(ady) << 8;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r <= x_start; ys_r <= y_start; dx_r <= dx; dy_r <= dy;
      keep_r <= (dx != '0) && (ady_sh > tl_prod) && (ady_sh < th_prod);
    end
  end

  // divider operand selection
  logic                     div_done;
  logic signed [QUO_W-1:0]  quo;
  logic signed [NUM_W-1:0]  num;
  logic signed [SUM_W-1:0]  den;
  logic [CNT_W-1:0] lcnt_r, rcnt_r;
  logic signed [SUM_W-1:0] lsm_r, lsb_r, rsm_r, rsb_r;
  logic [CNT_W-1:0]        n_sel;
  logic signed [SUM_W-1:0] sm_sel, sb_sel;
  logic [11:0]             row_sel;
  logic [CNT_W+11:0]       ny;

  always_comb begin
    n_sel  = cmd.col_side ? rcnt_r : lcnt_r;
    sm_sel = cmd.col_side ? rsm_r : lsm_r;
    sb_sel = cmd.col_side ? rsb_r : lsb_r;
    row_sel = cmd.col_row ? row_bottom : row_top;
    ny = (CNT_W+12)'(n_sel) * (CNT_W+12)'(row_sel);
    if (cmd.div_sel) begin
      num = $signed({{(NUM_W-CNT_W-28){1'b0}}, ny, 16'h0000}) - NUM_W'(sb_sel);
      den = sm_sel;
    end else begin
      num = NUM_W'(dy_r) <<< 16;
      den = SUM_W'(dx_r);
    end
  end

  lla_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num), .den(den), .done(div_done), .quo(quo)
  );

  // slope and intercept of the held segment
  logic signed [PW-1:0]  m;
  logic signed [PW+COORD_BITS:0] mx;
  logic signed [SUM_W-1:0] b;
  always_comb begin
    m = PW'(quo);
    mx = (PW+COORD_BITS+1)'(m) * $signed({1'b0, xs_r});
    b = $signed(SUM_W'({ys_r, 16'h0000})) - SUM_W'(mx);
  end

  // lane sums
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      lcnt_r <= '0; rcnt_r <= '0;
      lsm_r <= '0; lsb_r <= '0; rsm_r <= '0; rsb_r <= '0;
    end else if (cmd.accum) begin
      if (m < 0 && lcnt_r < CNT_W'(MAX_SEGMENTS)) begin
        lcnt_r <= lcnt_r + CNT_W'(1);
        lsm_r <= lsm_r + SUM_W'(m);
        lsb_r <= lsb_r + b;
      end else if (m > 0 && rcnt_r < CNT_W'(MAX_SEGMENTS)) begin
        rcnt_r <= rcnt_r + CNT_W'(1);
        rsm_r <= rsm_r + SUM_W'(m);
        rsb_r <= rsb_r + b;
      end
    end
  end

  // saturate and hold columns
  logic signed [15:0] sat, ctop_r, cbot_r;
  always_comb begin
    if (quo > 64'sd32767) sat = 16'sh7fff;
    else if (quo < -64'sd32768) sat = 16'sh8000;
    else sat = quo[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.col_save) begin
      if (cmd.col_row) cbot_r <= sat;
      else ctop_r <= sat;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_side <= cmd.col_side;
      o_found <= sts.lane_ok;
      o_col_top <= sts.lane_ok ? ctop_r : 16'sh0000;
      o_col_bottom <= sts.lane_ok ? cbot_r : 16'sh0000;
      o_top_row <= row_top;
      o_bottom_row <= row_bottom;
    end
  end

  assign sts = lla_sts_t'{keep: keep_r, div_done: div_done,
                          lane_ok: (n_sel != '0) && (sm_sel != '0)};
endmodule

// ===== src/lla_ctrl.sv =====
// lla_ctrl: sequencer for segment intake, slope division and frame-end emission
// depends on lla_pkg
`timescale 1ns / 1ps
module lla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_has_segment,
  input  logic              in_frame_last,
  output logic              out_valid,
  input  logic              out_stall,
  output lla_pkg::lla_cmd_t cmd,
  input  lla_pkg::lla_sts_t sts
);
  import lla_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_SDIV = 3'd2;
  localparam logic [2:0] S_CDIV = 3'd3;
  localparam logic [2:0] S_CWAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       side_r, side_nxt;
  logic       row_r, row_nxt;
  logic       ov_r, ov_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; last_nxt = last_r; side_nxt = side_r; row_nxt = row_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    cmd.col_side = side_r;
    cmd.col_row = row_r;
    cmd.div_sel = (state_r != S_SDIV) && (state_r != S_TEST);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          last_nxt = in_frame_last;
          if (in_has_segment) state_nxt = S_TEST;
          else if (in_frame_last) begin
            side_nxt = 1'b0; row_nxt = 1'b0; state_nxt = S_CDIV;
          end
        end
      end
      S_TEST: begin
        if (sts.keep) begin
          cmd.div_start = 1'b1;
          state_nxt = S_SDIV;
        end else if (last_r) begin
          side_nxt = 1'b0; row_nxt = 1'b0; state_nxt = S_CDIV;
        end else state_nxt = S_IDLE;
      end
      S_SDIV: begin
        if (sts.div_done) begin
          cmd.accum = 1'b1;
          if (last_r) begin
            side_nxt = 1'b0; row_nxt = 1'b0; state_nxt = S_CDIV;
          end else state_nxt = S_IDLE;
        end
      end
      S_CDIV: begin
        if (sts.lane_ok) begin
          cmd.div_start = 1'b1;
          state_nxt = S_CWAIT;
        end else state_nxt = S_EMIT;
      end
      S_CWAIT: begin
        if (sts.div_done) begin
          cmd.col_save = 1'b1;
          if (row_r) begin
            row_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            row_nxt = 1'b1;
            state_nxt = S_CDIV;
          end
        end
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          if (side_r) begin
            cmd.clear = 1'b1;
            state_nxt = S_HOLD;
          end else begin
            side_nxt = 1'b1;
            state_nxt = S_CDIV;
          end
        end
      end
      S_HOLD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt; side_r <= side_nxt; row_r <= row_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== sim/lane_line_averager_tb.sv =====
// lane_line_averager_tb: self-checking bench for the lane line averager
// depends on lla_pkg and lane_line_averager; drives segment words, folds them into
// lane sums of its own and checks every lane result word in order
`timescale 1ns / 1ps
module lane_line_averager_tb;
  import lla_pkg::*;

  typedef struct {
    bit        side;
    bit        found;
    bit [15:0] col_top;
    bit [11:0] top_row;
    bit [15:0] col_bottom;
    bit [11:0] bottom_row;
    bit        pair_last;
  } lane_word_t;

  typedef struct {
    bit        has_seg;
    bit [11:0] xs, ys, xe, ye;
    bit        last;
    bit        empty_pair;  // typed expectation: both lanes empty
  } seg_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_has_segment = 1'b0;
  logic [11:0] in_x_start = '0, in_y_start = '0, in_x_end = '0, in_y_end = '0;
  logic in_frame_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_lane_side, out_lane_found, out_pair_last;
  logic signed [15:0] out_col_top, out_col_bottom;
  logic [11:0] out_top_row, out_bottom_row;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  lane_line_averager i_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and lane sums
  int     thr_low = 148, thr_high = 1452, top_r = 208, bot_r = 320;
  int     lane_n[2];
  longint lane_sm[2], lane_sb[2];
  lane_word_t lane_queue[$];
  int     fail_count = 0;
  bit     calm = 1'b0;
  bit     hold_kick = 1'b0;
  int     hold_left = 0;

  function automatic void clear_lanes();
    for (int s = 0; s < 2; s++) begin
      lane_n[s] = 0;
      lane_sm[s] = 0;
      lane_sb[s] = 0;
    end
  endfunction

  function automatic void fold_segment(seg_word_t w);
    longint dx, dy, adx, ady, m, b;
    int s;
    dx = longint'(w.xe) - longint'(w.xs);
    dy = longint'(w.ye) - longint'(w.ys);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (dx == 0) return;
    if (!(ady * 256 > longint'(thr_low) * adx)) return;
    if (!(ady * 256 < longint'(thr_high) * adx)) return;
    m = (dy * 65536) / dx;
    b = longint'(w.ys) * 65536 - m * longint'(w.xs);
    if (m == 0) return;
    s = (m < 0) ? 0 : 1;
    if (lane_n[s] < 1024) begin
      lane_n[s]++;
      lane_sm[s] += m;
      lane_sb[s] += b;
    end
  endfunction

  function automatic bit [15:0] column_at(int n, int row, longint sm, longint sb);
    longint x;
    x = (longint'(n) * longint'(row) * 65536 - sb) / sm;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[15:0];
  endfunction

  // fold one word, queue the lane pair on a frame end
  function automatic void predict_word(seg_word_t w);
    lane_word_t r;
    bit ok;
    if (w.has_seg) fold_segment(w);
    if (!w.last) return;
    for (int s = 0; s < 2; s++) begin
      ok = lane_n[s] != 0 && lane_sm[s] != 0;
      r.side = s[0];
      r.found = ok;
      r.col_top = ok ? column_at(lane_n[s], top_r, lane_sm[s], lane_sb[s]) : 16'd0;
      r.top_row = top_r[11:0];
      r.col_bottom = ok ? column_at(lane_n[s], bot_r, lane_sm[s], lane_sb[s]) : 16'd0;
      r.bottom_row = bot_r[11:0];
      r.pair_last = s[0];
      lane_queue = {lane_queue, r};
    end
    clear_lanes();
  endfunction

  // result side: random stall, long hold on request, check each word
  always @(posedge clk) begin
    lane_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (lane_queue.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = lane_queue.pop_front();
        if (out_lane_side !== e.side) begin
          $error("lane_side exp %0d got %0d", e.side, out_lane_side); fail_count++;
        end
        if (out_lane_found !== e.found) begin
          $error("lane_found exp %0d got %0d", e.found, out_lane_found); fail_count++;
        end
        if (out_col_top !== e.col_top) begin
          $error("col_top exp %0d got %0d", $signed(e.col_top), out_col_top);
          fail_count++;
        end
        if (out_top_row !== e.top_row) begin
          $error("top_row exp %0d got %0d", e.top_row, out_top_row); fail_count++;
        end
        if (out_col_bottom !== e.col_bottom) begin
          $error("col_bottom exp %0d got %0d", $signed(e.col_bottom), out_col_bottom);
          fail_count++;
        end
        if (out_bottom_row !== e.bottom_row) begin
          $error("bottom_row exp %0d got %0d", e.bottom_row, out_bottom_row);
          fail_count++;
        end
        if (out_pair_last !== e.pair_last) begin
          $error("pair_last exp %0d got %0d", e.pair_last, out_pair_last); fail_count++;
        end
      end
    end
    if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // offer one word, idling first at random; valid stays high after acceptance
  task automatic send_word(seg_word_t w);
    lane_word_t r;
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_has_segment <= w.has_seg;
    in_x_start <= w.xs;
    in_y_start <= w.ys;
    in_x_end <= w.xe;
    in_y_end <= w.ye;
    in_frame_last <= w.last;
    do @(posedge clk); while (in_stall);
    if (w.empty_pair) begin
      // empty frame: both lanes not found, columns zero
      r = '{1'b0, 1'b0, 16'd0, top_r[11:0], 16'd0, bot_r[11:0], 1'b0};
      lane_queue = {lane_queue, r};
      r = '{1'b1, 1'b0, 16'd0, top_r[11:0], 16'd0, bot_r[11:0], 1'b1};
      lane_queue = {lane_queue, r};
      clear_lanes();
    end else begin
      predict_word(w);
    end
  endtask

  // drain all results, then let a trailing word settle
  task automatic drain();
    in_valid <= 1'b0;
    while (lane_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TAN_LOW:    thr_low = val & 16'hFFFF;
      REG_TAN_HIGH:   thr_high = val & 16'hFFFF;
      REG_ROW_TOP:    top_r = val & 12'hFFF;
      REG_ROW_BOTTOM: bot_r = val & 12'hFFF;
      default: ;
    endcase
  endtask

  function automatic seg_word_t rand_word(bit last);
    seg_word_t w;
    int adx, ady;
    w.empty_pair = 1'b0;
    w.last = last;
    w.has_seg = $urandom_range(99) < 90;
    if ($urandom_range(99) < 25) begin
      // raw noise over the whole coordinate range
      w.xs = 12'($urandom); w.ys = 12'($urandom);
      w.xe = 12'($urandom); w.ye = 12'($urandom);
    end else begin
      // plausible lane segment, either lean
      adx = $urandom_range(1, 300);
      ady = $urandom_range(0, adx * 7);
      if (ady > 4000) ady = 4000;
      w.xs = 12'($urandom_range(0, 4095 - adx));
      w.xe = 12'(int'(w.xs) + adx);
      w.ys = 12'($urandom_range(0, 4095 - ady));
      w.ye = 12'(int'(w.ys) + ady);
      if ($urandom_range(1)) begin
        w.ys = 12'(int'(w.ys) + ady);
        w.ye = 12'(int'(w.ye) - ady);
      end
      if ($urandom_range(1)) begin
        w.xs = 12'(int'(w.xs) + adx);
        w.xe = 12'(int'(w.xe) - adx);
      end
    end
    return w;
  endfunction

  task automatic run_frames(int n_words);
    int k;
    int len;
    k = 0;
    while (k < n_words) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_word(rand_word(i == len - 1));
      k += len;
    end
  endtask

  // directed words under reset settings
  seg_word_t directed[] = '{
    '{1'b0, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 1'b1},
    '{1'b1, 12'd0,    12'd0,    12'd4095, 12'd4095, 1'b0, 1'b0},
    '{1'b1, 12'd4095, 12'd0,    12'd0,    12'd4095, 1'b0, 1'b0},
    '{1'b1, 12'd100,  12'd100,  12'd100,  12'd400,  1'b0, 1'b0},
    '{1'b1, 12'd0,    12'd5,    12'd4095, 12'd5,    1'b0, 1'b0},
    '{1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0},
    '{1'b1, 12'd10,   12'd300,  12'd60,   12'd250,  1'b1, 1'b0},
    '{1'b1, 12'd0,    12'd0,    12'd256,  12'd148,  1'b0, 1'b0},
    '{1'b1, 12'd0,    12'd0,    12'd256,  12'd1452, 1'b0, 1'b0},
    '{1'b1, 12'd0,    12'd0,    12'd256,  12'd149,  1'b1, 1'b0},
    '{1'b1, 12'd7,    12'd7,    12'd7,    12'd9,    1'b1, 1'b1},
    '{1'b1, 12'd4095, 12'd4095, 12'd0,    12'd0,    1'b0, 1'b0},
    '{1'b1, 12'd0,    12'd4095, 12'd4095, 12'd0,    1'b1, 1'b0},
    '{1'b1, 12'd200,  12'd200,  12'd100,  12'd300,  1'b1, 1'b0}
  };

  // main sequence
  initial begin
    seg_word_t w;
    clear_lanes();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i]);

    // one frame of many identical right-lane segments
    w = '{1'b1, 12'd0, 12'd0, 12'd1, 12'd1, 1'b0, 1'b0};
    for (int i = 0; i < 60; i++) begin
      w.last = (i == 59);
      send_word(w);
    end
    drain();

    // widest window, rows at extremes
    write_reg(REG_TAN_LOW, 0);
    write_reg(REG_TAN_HIGH, 65535);
    write_reg(REG_ROW_TOP, 0);
    write_reg(REG_ROW_BOTTOM, 4095);
    run_frames(150);

    // receiver holds off while words keep coming
    hold_kick = 1'b1;
    run_frames(40);
    drain();

    // closed window, rows swapped
    write_reg(REG_TAN_LOW, 65535);
    write_reg(REG_TAN_HIGH, 65535);
    write_reg(REG_ROW_TOP, 4095);
    write_reg(REG_ROW_BOTTOM, 0);
    run_frames(60);
    drain();

    // defaults again, no idling on either side
    write_reg(REG_TAN_LOW, 148);
    write_reg(REG_TAN_HIGH, 1452);
    write_reg(REG_ROW_TOP, 208);
    write_reg(REG_ROW_BOTTOM, 320);
    calm = 1'b1;
    run_frames(150);
    drain();
    calm = 1'b0;

    // random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_TAN_LOW, $urandom_range(0, 600));
      write_reg(REG_TAN_HIGH, $urandom_range(300, 4000));
      write_reg(REG_ROW_TOP, $urandom_range(0, 4095));
      write_reg(REG_ROW_BOTTOM, $urandom_range(0, 4095));
      run_frames(60);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
